// File: design/pqdk_pkg.sv
`timescale 1ns / 1ps

package pqdk_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_SET     = 2'd2,
    REQ_IGNORE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_MIN      = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] value;
  } entry_t;

endpackage

// File: design/priority_queue_with_decrease_key_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake         Payload
// s_*      in         s_tvalid/s_tready tdata: key_value[31:0], target_op[63:32]
//                                       tuser: req_type[1:0]
// m_*      out        m_tvalid/m_tready tdata: min_value[31:0]; tuser: status[1:0]
//
// A push writes the store; to a full store it reports full. Extract-min and set-value issue
// the first read in the transfer cycle, then scan one entry per cycle from the newest
// down: extract scans all occupancy entries, set-value stops at the match.
// Extract then moves each newer entry down one slot, one per cycle. Any result passes
// through the emit state. Reset is synchronous; occupancy marks valid slots.
// A result waits in the output register; the emit state holds while it is still full.

module priority_queue_with_decrease_key_top #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // key_value[31:0], target_op[63:32]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // min_value[31:0]
  output logic [1:0]  m_tuser    // status[1:0]
);
  import pqdk_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t             state, state_next;
  logic [31:0]        op_counter, op_counter_next;
  logic [CNT_W-1:0]   occ, occ_next;
  req_t               req, req_next;
  logic [31:0]        key, key_next;
  logic [31:0]        target, target_next;
  logic [IDX_W-1:0]   cmp_idx, cmp_idx_next;
  logic [IDX_W-1:0]   best_idx, best_idx_next;
  logic signed [31:0] best_val, best_val_next;
  status_t            res_status, res_status_next;
  logic [31:0]        res_value, res_value_next;
  logic               m_tvalid_next;
  logic [31:0]        m_tdata_next;
  logic [1:0]         m_tuser_next;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  entry_t             rd_data;

  logic [CNT_W-1:0]   occ_m1, occ_m2;
  logic [IDX_W-1:0]   last_idx;
  logic signed [31:0] rd_val, cand_val;
  logic [IDX_W-1:0]   cand_idx;
  logic               take;

  pqdk_store #(.DEPTH(CAPACITY), .AW(IDX_W)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign s_tready = (state == ST_IDLE);
  assign occ_m1   = occ - CNT_W'(1);
  assign occ_m2   = occ - CNT_W'(2);
  assign last_idx = occ_m1[IDX_W-1:0];
  assign rd_val   = signed'(rd_data.value);
  // ties keep the newer entry: only a strictly smaller value takes over
  assign take     = (cmp_idx == last_idx) || (rd_val < best_val);
  assign cand_val = take ? rd_val : best_val;
  assign cand_idx = take ? cmp_idx : best_idx;

  always_comb begin
    state_next      = state;
    op_counter_next = op_counter;
    occ_next        = occ;
    req_next        = req;
    key_next        = key;
    target_next     = target;
    cmp_idx_next    = cmp_idx;
    best_idx_next   = best_idx;
    best_val_next   = best_val;
    res_status_next = res_status;
    res_value_next  = res_value;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    m_tuser_next    = m_tuser;
    mem_we          = 1'b0;
    mem_waddr       = cmp_idx;
    mem_wdata       = rd_data;
    mem_raddr       = cmp_idx - IDX_W'(1);

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          req_next    = req_t'(s_tuser);
          key_next    = s_tdata[31:0];
          target_next = s_tdata[63:32];
          if (req_t'(s_tuser) != REQ_IGNORE) begin
            op_counter_next = op_counter + 32'd1;
          end
          unique case (req_t'(s_tuser))
            REQ_PUSH: begin
              if (occ == CNT_W'(CAPACITY)) begin
                res_status_next = STAT_FULL;
                res_value_next  = '0;
                state_next      = ST_EMIT;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = occ[IDX_W-1:0];
                mem_wdata.tag   = op_counter;
                mem_wdata.value = s_tdata[31:0];
                occ_next        = occ + CNT_W'(1);
              end
            end
            REQ_EXTRACT, REQ_SET: begin
              if (occ == '0) begin
                res_status_next = (req_t'(s_tuser) == REQ_EXTRACT) ? STAT_EMPTY
                                                                   : STAT_NOTFOUND;
                res_value_next  = '0;
                state_next      = ST_EMIT;
              end else begin
                mem_raddr    = last_idx;
                cmp_idx_next = last_idx;
                state_next   = ST_SCAN;
              end
            end
            REQ_IGNORE: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        cmp_idx_next = cmp_idx - IDX_W'(1);
        if (req == REQ_SET) begin
          if (rd_data.tag == target) begin
            mem_we          = 1'b1;
            mem_waddr       = cmp_idx;
            mem_wdata.tag   = rd_data.tag;
            mem_wdata.value = key;
            state_next      = ST_IDLE;
          end else if (cmp_idx == '0) begin
            res_status_next = STAT_NOTFOUND;
            res_value_next  = '0;
            state_next      = ST_EMIT;
          end
        end else begin
          best_val_next = cand_val;
          best_idx_next = cand_idx;
          if (cmp_idx == '0) begin
            res_status_next = STAT_MIN;
            res_value_next  = cand_val;
            if (cand_idx == last_idx) begin
              occ_next   = occ_m1;
              state_next = ST_EMIT;
            end else begin
              mem_raddr    = cand_idx + IDX_W'(1);
              cmp_idx_next = cand_idx;
              state_next   = ST_SHIFT;
            end
          end
        end
      end

      ST_SHIFT: begin
        mem_we       = 1'b1;
        mem_waddr    = cmp_idx;
        mem_wdata    = rd_data;
        mem_raddr    = cmp_idx + IDX_W'(2);
        cmp_idx_next = cmp_idx + IDX_W'(1);
        if (cmp_idx == occ_m2[IDX_W-1:0]) begin
          occ_next   = occ_m1;
          state_next = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = res_value;
          m_tuser_next  = res_status;
          state_next    = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      op_counter <= 32'd1;
      occ        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      op_counter <= op_counter_next;
      occ        <= occ_next;
      m_tvalid   <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    key        <= key_next;
    target     <= target_next;
    cmp_idx    <= cmp_idx_next;
    best_idx   <= best_idx_next;
    best_val   <= best_val_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    m_tdata    <= m_tdata_next;
    m_tuser    <= m_tuser_next;
  end

endmodule

// File: design/pqdk_store.sv
`timescale 1ns / 1ps

module pqdk_store #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  pqdk_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output pqdk_pkg::entry_t rdata
);
  import pqdk_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/pqdk_checker.sv
`timescale 1ns / 1ps

module pqdk_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import pqdk_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STAT_MIN) |-> m_tdata == 32'd0)
    else $error("nonzero value with a failure status");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == REQ_EXTRACT || s_tuser == REQ_SET)
      |=> !s_tready)
    else $error("input taken while a search is under way");

endmodule

bind priority_queue_with_decrease_key_top pqdk_checker u_pqdk_checker (.*);
